### src/e2c_pkg.sv
package e2c_pkg;

    // field widths
    localparam int EpochW  = 32;
    localparam int ZoneW   = 18;
    localparam int LocalW  = EpochW + 1;
    localparam int RemW    = 17;
    localparam int DaysW   = 16;
    localparam int SecW    = 6;
    localparam int HourW   = 5;
    localparam int DayW    = 5;
    localparam int MonW    = 4;
    localparam int YearW   = 8;

    // divider constants
    localparam int MulAW   = 26;
    localparam int MulBW   = 27;
    localparam int ProdW   = MulAW + MulBW;
    localparam int DivSelW = 2;
    localparam logic [DivSelW-1:0] DivByDay  = 2'd0;
    localparam logic [DivSelW-1:0] DivByHour = 2'd1;
    localparam logic [DivSelW-1:0] DivByMin  = 2'd2;
    localparam logic [RemW-1:0] SecsPerDay  = 17'd86400;
    localparam logic [RemW-1:0] SecsPerHour = 17'd3600;
    localparam logic [RemW-1:0] SecsPerMin  = 17'd60;

    // quotient = ((x >> pre) * recip) >> post, exact over the range of each pass
    localparam int DayPre   = 7;
    localparam int DayPost  = 36;
    localparam logic [MulBW-1:0] DayRecip  = 27'd101806633;
    localparam int HourPre  = 4;
    localparam int HourPost = 21;
    localparam logic [MulBW-1:0] HourRecip = 27'd9321;
    localparam int MinPre   = 2;
    localparam int MinPost  = 14;
    localparam logic [MulBW-1:0] MinRecip  = 27'd1093;

    // calendar constants, years counted from 1900
    localparam logic [YearW-1:0] YearBase      = 8'd70;
    localparam logic [YearW-1:0] NoLeapCentury = 8'd200;
    localparam logic [MonW-1:0]  MonFeb        = 4'd1;
    localparam logic [MonW-1:0]  MonApr        = 4'd3;
    localparam logic [MonW-1:0]  MonJun        = 4'd5;
    localparam logic [MonW-1:0]  MonSep        = 4'd8;
    localparam logic [MonW-1:0]  MonNov        = 4'd10;

    typedef struct packed {
        logic               start;
        logic [LocalW-1:0]  dividend;
        logic [DivSelW-1:0] sel;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [LocalW-1:0] quot;
        logic [RemW-1:0]   rem;
    } t_div_rsp;

    typedef struct packed {
        logic             start;
        logic [DaysW-1:0] days;
    } t_date_req;

    typedef struct packed {
        logic             done;
        logic [DayW-1:0]  day;
        logic [MonW-1:0]  mon;
        logic [YearW-1:0] year;
    } t_date_rsp;

    // gregorian leap rule over 1970..2106: only 2100 is a skipped century
    function automatic logic is_leap(input logic [YearW-1:0] y);
        is_leap = (y[1:0] == 2'b00) && (y != NoLeapCentury);
    endfunction

    function automatic logic [8:0] year_len(input logic [YearW-1:0] y);
        year_len = is_leap(y) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m,
                                                  input logic leap);
        logic [DayW-1:0] len;
        len = 5'd31;
        case (m)
            MonFeb: len = leap ? 5'd29 : 5'd28;
            MonApr, MonJun, MonSep, MonNov: len = 5'd30;
            default: len = 5'd31;
        endcase
        month_len = len;
    endfunction

endpackage

### src/e2c_div.sv
module e2c_div
    import e2c_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam logic [2:0] PhIdle  = 3'd0;
    localparam logic [2:0] PhQuot  = 3'd1;
    localparam logic [2:0] PhShift = 3'd2;
    localparam logic [2:0] PhBack  = 3'd3;
    localparam logic [2:0] PhRem   = 3'd4;

    logic [2:0]         r_phase, n_phase;
    logic               r_done, n_done;
    logic [DivSelW-1:0] r_sel, n_sel;
    logic [LocalW-1:0]  r_x, n_x;
    logic [ProdW-1:0]   r_p, n_p;
    logic [LocalW-1:0]  r_q, n_q;
    logic [RemW-1:0]    r_r, n_r;
    logic [MulAW-1:0]   scaled;
    logic [MulBW-1:0]   recip;
    logic [MulBW-1:0]   divisor;
    logic [LocalW-1:0]  quot;
    logic [MulAW-1:0]   mul_a;
    logic [MulBW-1:0]   mul_b;
    logic [ProdW-1:0]   prod;
    logic [LocalW-1:0]  rem_full;

    // reciprocal, shifts and divisor of the selected pass
    always_comb begin
        case (r_sel)
            DivByDay: begin
                scaled  = r_x[DayPre +: MulAW];
                recip   = DayRecip;
                quot    = LocalW'(r_p >> DayPost);
                divisor = {{(MulBW - RemW){1'b0}}, SecsPerDay};
            end
            DivByHour: begin
                scaled  = r_x[HourPre +: MulAW];
                recip   = HourRecip;
                quot    = LocalW'(r_p >> HourPost);
                divisor = {{(MulBW - RemW){1'b0}}, SecsPerHour};
            end
            default: begin
                scaled  = r_x[MinPre +: MulAW];
                recip   = MinRecip;
                quot    = LocalW'(r_p >> MinPost);
                divisor = {{(MulBW - RemW){1'b0}}, SecsPerMin};
            end
        endcase
    end

    // one shared multiplier: reciprocal first, then quotient times divisor
    always_comb begin
        mul_a = scaled;
        mul_b = recip;
        if (r_phase == PhBack) begin
            mul_a = r_q[MulAW-1:0];
            mul_b = divisor;
        end
    end

    assign prod     = ProdW'(mul_a) * ProdW'(mul_b);
    assign rem_full = r_x - r_p[LocalW-1:0];

    // multiply, take quotient, multiply back, subtract
    always_comb begin
        n_phase = r_phase;
        n_done  = 1'b0;
        n_sel   = r_sel;
        n_x     = r_x;
        n_p     = r_p;
        n_q     = r_q;
        n_r     = r_r;
        if (i_req.start) begin
            n_phase = PhQuot;
            n_sel   = i_req.sel;
            n_x     = i_req.dividend;
        end else begin
            case (r_phase)
                PhQuot: begin
                    n_p     = prod;
                    n_phase = PhShift;
                end
                PhShift: begin
                    n_q     = quot;
                    n_phase = PhBack;
                end
                PhBack: begin
                    n_p     = prod;
                    n_phase = PhRem;
                end
                PhRem: begin
                    n_r     = rem_full[RemW-1:0];
                    n_done  = 1'b1;
                    n_phase = PhIdle;
                end
                default: n_phase = PhIdle;
            endcase
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PhIdle;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_sel <= n_sel;
        r_x   <= n_x;
        r_p   <= n_p;
        r_q   <= n_q;
        r_r   <= n_r;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_r;

endmodule

### src/e2c_date.sv
module e2c_date
    import e2c_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_date_req i_req,
    output t_date_rsp o_rsp
);

    localparam logic [1:0] StIdle  = 2'd0;
    localparam logic [1:0] StYear  = 2'd1;
    localparam logic [1:0] StMonth = 2'd2;

    logic [1:0]       r_state, n_state;
    logic             r_done, n_done;
    logic [DaysW-1:0] r_left, n_left;
    logic [YearW-1:0] r_year, n_year;
    logic [MonW-1:0]  r_mon, n_mon;
    logic [8:0]       ylen;
    logic [DayW-1:0]  mlen;

    assign ylen = year_len(r_year);
    assign mlen = month_len(r_mon, is_leap(r_year));

    // walk whole years, then whole months, off the day count
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_left  = r_left;
        n_year  = r_year;
        n_mon   = r_mon;
        case (r_state)
            StIdle: begin
                if (i_req.start) begin
                    n_left  = i_req.days;
                    n_year  = YearBase;
                    n_mon   = '0;
                    n_state = StYear;
                end
            end
            StYear: begin
                if (r_left >= DaysW'(ylen)) begin
                    n_left = r_left - DaysW'(ylen);
                    n_year = r_year + 1'b1;
                end else begin
                    n_state = StMonth;
                end
            end
            StMonth: begin
                if (r_left >= DaysW'(mlen)) begin
                    n_left = r_left - DaysW'(mlen);
                    n_mon  = r_mon + 1'b1;
                end else begin
                    n_done  = 1'b1;
                    n_state = StIdle;
                end
            end
            default: n_state = StIdle;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_left <= n_left;
        r_year <= n_year;
        r_mon  <= n_mon;
    end

    // remaining days are below the month length here
    assign o_rsp.done = r_done;
    assign o_rsp.day  = r_left[DayW-1:0] + 1'b1;
    assign o_rsp.mon  = r_mon;
    assign o_rsp.year = r_year;

endmodule

### src/epoch_seconds_to_calendar_date.sv
// Converts an unsigned epoch second count to local second, minute, hour, day of month,
// month (0 = January) and year since 1900, after subtracting the signed zone offset
// register (a negative local time clamps to 1970-01-01 00:00:00). Gregorian leap rules
// apply, so 2000 is a leap year and 2100 is not. One transaction is converted at a time:
// o_stall is high from acceptance until the result is loaded into the output register.
// A conversion runs from acceptance to o_valid as three passes through one shared
// reciprocal multiplier (by 86400, 3600 and 60), then a year-by-year and month-by-month
// walk of the day count. A new transaction is not taken before the last one is done;
// while an earlier result still waits at the output the finished conversion holds, and
// the next transaction may be accepted once it is loaded.
module epoch_seconds_to_calendar_date
    import e2c_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [ZoneW-1:0]  i_cfg_wr_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [EpochW-1:0] i_epoch_seconds,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [SecW-1:0]   o_second_of_minute,
    output logic [SecW-1:0]   o_minute_of_hour,
    output logic [HourW-1:0]  o_hour_of_day,
    output logic [DayW-1:0]   o_day_of_month,
    output logic [MonW-1:0]   o_month_index,
    output logic [YearW-1:0]  o_year_since_1900
);

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StDay  = 3'd1;
    localparam logic [2:0] StHour = 3'd2;
    localparam logic [2:0] StMin  = 3'd3;
    localparam logic [2:0] StDate = 3'd4;
    localparam logic [2:0] StDone = 3'd5;

    logic [ZoneW-1:0]  r_zone;
    logic [2:0]        r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic [DaysW-1:0]  r_days, n_days;
    logic [HourW-1:0]  r_hour, n_hour;
    logic [SecW-1:0]   r_min, n_min;
    logic [SecW-1:0]   r_sec, n_sec;
    logic [SecW-1:0]   r_o_sec, n_o_sec;
    logic [SecW-1:0]   r_o_min, n_o_min;
    logic [HourW-1:0]  r_o_hour, n_o_hour;
    logic [DayW-1:0]   r_o_day, n_o_day;
    logic [MonW-1:0]   r_o_mon, n_o_mon;
    logic [YearW-1:0]  r_o_year, n_o_year;
    logic [LocalW:0]   diff;
    logic [LocalW-1:0] local_secs;
    logic              in_take;
    logic              out_free;
    t_div_req          div_req;
    t_div_rsp          div_rsp;
    t_date_req         date_req;
    t_date_rsp         date_rsp;

    // zone offset register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= '0;
        end else if (i_cfg_wr_en) begin
            r_zone <= i_cfg_wr_data;
        end
    end

    // local time with clamp at zero
    assign diff = {2'b00, i_epoch_seconds}
                - {{(LocalW + 1 - ZoneW){r_zone[ZoneW-1]}}, r_zone};
    assign local_secs = diff[LocalW] ? '0 : diff[LocalW-1:0];

    assign o_stall  = (r_state != StIdle);
    assign in_take  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    e2c_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    e2c_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (date_req),
        .o_rsp   (date_rsp)
    );

    // sequencer over the shared divider and the date walker
    always_comb begin
        n_state          = r_state;
        n_days           = r_days;
        n_hour           = r_hour;
        n_min            = r_min;
        n_sec            = r_sec;
        n_out_valid      = r_out_valid && i_stall;
        n_o_sec          = r_o_sec;
        n_o_min          = r_o_min;
        n_o_hour         = r_o_hour;
        n_o_day          = r_o_day;
        n_o_mon          = r_o_mon;
        n_o_year         = r_o_year;
        div_req.start    = 1'b0;
        div_req.dividend = local_secs;
        div_req.sel      = DivByDay;
        date_req.start   = 1'b0;
        date_req.days    = r_days;
        case (r_state)
            StIdle: begin
                if (in_take) begin
                    div_req.start = 1'b1;
                    n_state       = StDay;
                end
            end
            StDay: begin
                div_req.dividend = {{(LocalW - RemW){1'b0}}, div_rsp.rem};
                div_req.sel      = DivByHour;
                if (div_rsp.done) begin
                    n_days        = div_rsp.quot[DaysW-1:0];
                    div_req.start = 1'b1;
                    n_state       = StHour;
                end
            end
            StHour: begin
                div_req.dividend = {{(LocalW - RemW){1'b0}}, div_rsp.rem};
                div_req.sel      = DivByMin;
                if (div_rsp.done) begin
                    n_hour        = div_rsp.quot[HourW-1:0];
                    div_req.start = 1'b1;
                    n_state       = StMin;
                end
            end
            StMin: begin
                if (div_rsp.done) begin
                    n_min          = div_rsp.quot[SecW-1:0];
                    n_sec          = div_rsp.rem[SecW-1:0];
                    date_req.start = 1'b1;
                    n_state        = StDate;
                end
            end
            StDate: begin
                if (date_rsp.done) begin
                    n_state = StDone;
                end
            end
            // the date walker holds its result until the next start
            StDone: begin
                if (out_free) begin
                    n_o_sec     = r_sec;
                    n_o_min     = r_min;
                    n_o_hour    = r_hour;
                    n_o_day     = date_rsp.day;
                    n_o_mon     = date_rsp.mon;
                    n_o_year    = date_rsp.year;
                    n_out_valid = 1'b1;
                    n_state     = StIdle;
                end
            end
            default: n_state = StIdle;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // working and output registers
    always_ff @(posedge i_clk) begin
        r_days   <= n_days;
        r_hour   <= n_hour;
        r_min    <= n_min;
        r_sec    <= n_sec;
        r_o_sec  <= n_o_sec;
        r_o_min  <= n_o_min;
        r_o_hour <= n_o_hour;
        r_o_day  <= n_o_day;
        r_o_mon  <= n_o_mon;
        r_o_year <= n_o_year;
    end

    assign o_valid            = r_out_valid;
    assign o_second_of_minute = r_o_sec;
    assign o_minute_of_hour   = r_o_min;
    assign o_hour_of_day      = r_o_hour;
    assign o_day_of_month     = r_o_day;
    assign o_month_index      = r_o_mon;
    assign o_year_since_1900  = r_o_year;

endmodule

### test/epoch_seconds_to_calendar_date_test.sv
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_date_test;
    import e2c_pkg::*;

    // one converted timestamp, as the block presents it
    typedef struct packed {
        logic [SecW-1:0]  sec;
        logic [SecW-1:0]  minute;
        logic [HourW-1:0] hour;
        logic [DayW-1:0]  mday;
        logic [MonW-1:0]  month;
        logic [YearW-1:0] year;
    } t_date;

    // directed row: zone setting, timestamp and, where obvious, the date by hand
    typedef struct {
        logic [ZoneW-1:0]  zone;
        logic [EpochW-1:0] secs;
        bit                typed;
        t_date             want;
    } t_probe;

    localparam logic [ZoneW-1:0] ZoneWestDay = 18'h15180;   // +86400
    localparam logic [ZoneW-1:0] ZoneEastDay = 18'h2AE80;   // -86400
    localparam logic [ZoneW-1:0] ZoneHigh    = 18'h1FFFF;
    localparam logic [ZoneW-1:0] ZoneLow     = 18'h20000;
    localparam t_date Dawn = '{6'd0, 6'd0, 5'd0, 5'd1, 4'd0, 8'd70};
    localparam int NumProbes = 24;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [ZoneW-1:0]  i_cfg_wr_data;
    logic              i_valid;
    logic              o_stall;
    logic [EpochW-1:0] i_epoch_seconds;
    logic              o_valid;
    logic              i_stall;
    logic [SecW-1:0]   o_second_of_minute;
    logic [SecW-1:0]   o_minute_of_hour;
    logic [HourW-1:0]  o_hour_of_day;
    logic [DayW-1:0]   o_day_of_month;
    logic [MonW-1:0]   o_month_index;
    logic [YearW-1:0]  o_year_since_1900;

    t_date                   dates_due[$];
    logic signed [ZoneW-1:0] zone_now;
    t_probe                  probes[NumProbes];
    int                      errors;
    int                      hold_req;

    epoch_seconds_to_calendar_date i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_epoch_seconds    (i_epoch_seconds),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_second_of_minute (o_second_of_minute),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_hour_of_day      (o_hour_of_day),
        .o_day_of_month     (o_day_of_month),
        .o_month_index      (o_month_index),
        .o_year_since_1900  (o_year_since_1900)
    );

    always #5 i_clk = ~i_clk;

    // local date of a timestamp, gregorian civil calendar from a day count
    function automatic t_date calendar_of(input logic [EpochW-1:0] secs,
                                          input logic signed [ZoneW-1:0] zone);
        longint t, days, z, era, doe, yoe, doy, mp, d, m, y;
        t_date  r;
        t = longint'(secs) - longint'(zone);
        if (t < 0)
            t = 0;
        r.sec    = SecW'(t % 60);
        t        = t / 60;
        r.minute = SecW'(t % 60);
        t        = t / 60;
        r.hour   = HourW'(t % 24);
        days     = t / 24;
        // eras of 400 years, each year starting in march
        z   = days + 719468;
        era = z / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        d   = doy - (153 * mp + 2) / 5 + 1;
        m   = (mp < 10) ? mp + 3 : mp - 9;
        y   = yoe + era * 400;
        if (m <= 2)
            y = y + 1;
        r.mday  = DayW'(d);
        r.month = MonW'(m - 1);
        r.year  = YearW'(y - 1900);
        return r;
    endfunction

    // idle length per transaction, with occasional stretches of none
    function automatic int pause_len(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    // stop offering and wait for every outstanding date
    task automatic drain();
        i_valid <= 1'b0;
        while (dates_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_zone(input logic [ZoneW-1:0] zone);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= zone;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        zone_now = zone;
    endtask

    // offer one timestamp and queue its date once the transaction is taken
    task automatic send_epoch(input logic [EpochW-1:0] secs, input int gap,
                              input bit typed, input t_date want);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_epoch_seconds <= secs;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        dates_due.push_back(typed ? want : calendar_of(secs, zone_now));
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // result side: compare every accepted date with the oldest one due
    always @(posedge i_clk) begin
        t_date want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (dates_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %0d-%0d-%0d",
                         $time, o_year_since_1900, o_month_index, o_day_of_month);
            end else begin
                want = dates_due.pop_front();
                check_field("second", want.sec, o_second_of_minute);
                check_field("minute", want.minute, o_minute_of_hour);
                check_field("hour", want.hour, o_hour_of_day);
                check_field("day", want.mday, o_day_of_month);
                check_field("month", want.month, o_month_index);
                check_field("year", want.year, o_year_since_1900);
            end
        end
    end

    // result side stall, with one long hold-off on request
    initial begin
        int w, calm;
        calm    = 0;
        i_stall = 1'b0;
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            if (hold_req > 0) begin
                w        = hold_req;
                hold_req = 0;
            end else begin
                w = pause_len(calm);
            end
            if (w > 0) begin
                i_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!o_valid)
                @(posedge i_clk);
        end
    end

    initial begin
        #30_000_000;
        $display("epoch_seconds_to_calendar_date_test: errors");
        $finish;
    end

    // stimulus
    initial begin
        int i, p, k, y, off, part, calm_tx;
        longint s, d;
        logic [ZoneW-1:0] z;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        i_valid         = 1'b0;
        i_epoch_seconds = '0;
        zone_now        = '0;
        errors          = 0;
        hold_req        = 0;
        calm_tx         = 0;

        probes = '{
            '{18'h0, 32'd0,          1'b1, Dawn},
            '{18'h0, 32'hFFFFFFFF,   1'b1, '{6'd15, 6'd28, 5'd6, 5'd7, 4'd1, 8'd206}},
            '{18'h0, 32'd59,         1'b0, '0},
            '{18'h0, 32'd60,         1'b0, '0},
            '{18'h0, 32'd86399,      1'b0, '0},
            '{18'h0, 32'd68169600,   1'b0, '0},   // first leap day
            '{18'h0, 32'd946684799,  1'b0, '0},
            '{18'h0, 32'd951782400,  1'b0, '0},   // leap day of a 400-year century
            '{18'h0, 32'd4107542399, 1'b0, '0},   // 2100 has no leap day
            '{18'h0, 32'd4107542400, 1'b0, '0},
            '{18'h0, 32'h7FFFFFFF,   1'b0, '0},
            '{18'h0, 32'h80000000,   1'b0, '0},
            '{18'h0, 32'hAAAAAAAA,   1'b0, '0},
            '{18'h0, 32'h55555555,   1'b0, '0},
            '{ZoneWestDay, 32'd5,        1'b1, Dawn},   // negative local time clamps
            '{ZoneWestDay, 32'd86400,    1'b1, Dawn},
            '{ZoneWestDay, 32'hFFFFFFFF, 1'b0, '0},
            '{ZoneEastDay, 32'd0,        1'b0, '0},
            '{ZoneEastDay, 32'hFFFFFFFF, 1'b0, '0},
            '{ZoneLow, 32'hFFFFFFFF, 1'b1, '{6'd47, 6'd52, 5'd18, 5'd8, 4'd1, 8'd206}},
            '{ZoneLow, 32'd0,        1'b0, '0},
            '{ZoneHigh, 32'd131070,  1'b1, Dawn},
            '{ZoneHigh, 32'd131071,  1'b1, Dawn},
            '{ZoneHigh, 32'hFFFFFFFF, 1'b0, '0}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (i = 0; i < NumProbes; i++) begin
            if (probes[i].zone != zone_now)
                set_zone(probes[i].zone);
            send_epoch(probes[i].secs, pause_len(calm_tx), probes[i].typed, probes[i].want);
        end

        // random phases, one zone setting each
        for (p = 0; p < 8; p++) begin
            case (p)
                0: z = ZoneW'($urandom_range(0, 172800) - 86400);
                1: z = ZoneWestDay;
                2: z = ZoneEastDay;
                3: z = '0;
                4: z = ZoneHigh;
                5: z = ZoneLow;
                default: z = ZoneW'($urandom);
            endcase
            set_zone(z);
            // all dates are in: hold the result side while transactions keep coming
            if (p == 3)
                hold_req = 2500;
            for (i = 0; i < 210; i++) begin
                k = $urandom_range(0, 9);
                if (k < 4) begin
                    s = $urandom;
                end else if (k < 7 || k == 9) begin
                    // around new year and the end of february of a random year, or on any day of it
                    y = $urandom_range(1970, 2106);
                    d = 365 * (y - 1970) + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 - 477;
                    if (k == 9) begin
                        d = d + $urandom_range(0, 365);
                    end else begin
                        off = $urandom_range(0, 4);
                        if (off < 2)
                            d = d + off - 1;
                        else
                            d = d + off + 56;
                    end
                    part = $urandom_range(0, 2);
                    s = d * 86400;
                    if (part == 1)
                        s = s + 86399;
                    else if (part == 2)
                        s = s + $urandom_range(0, 86399);
                end else if (k == 7) begin
                    s = $urandom_range(0, 200000);
                end else begin
                    s = 32'hFFFFFFFF - $urandom_range(0, 200000);
                end
                if (s < 0 || s > longint'(32'hFFFFFFFF))
                    s = $urandom;
                send_epoch(EpochW'(s), (p == 3 && i < 16) ? 0 : pause_len(calm_tx),
                           1'b0, '0);
            end
        end

        drain();
        repeat (300) @(posedge i_clk);
        if (errors == 0)
            $display("epoch_seconds_to_calendar_date_test: clean");
        else
            $display("epoch_seconds_to_calendar_date_test: errors");
        $finish;
    end

endmodule
